// File: src/tav_pkg.sv
`default_nettype none

package tav_pkg;

	// Pool size and derived widths
	localparam int NUM_VOICES  = 16;
	localparam int MAX_RESULTS = 16;
	localparam int VIDX_W      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int LINK_W      = $clog2(NUM_VOICES + 1);
	localparam int CNT_W       = $clog2(NUM_VOICES + 1);
	localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);
	localparam int DELAY_W     = 16;
	localparam int VOICE_W     = 4;
	localparam int ALIVE_W     = 5;

	// Operation codes
	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_ALLOC   = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_CLEAR   = 2'd2;
	localparam logic [1:0] KIND_EMPTY   = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		logic                clear;
		logic                step;
		logic                alloc_wr;
		logic [VIDX_W-1:0]   alloc_voice;
		logic [DELAY_W-1:0]  alloc_delay;
		logic [LINK_W-1:0]   free_head;
		logic                rel_full;
	} cell_ctl_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic [VOICE_W-1:0]  voice;
		logic [ALIVE_W-1:0]  alive;
		logic                last;
	} res_t;

	function automatic logic [VOICE_W-1:0] to_voice(input logic [VIDX_W-1:0] v);
		logic [31:0] t;
		t = 32'(v);
		return t[VOICE_W-1:0];
	endfunction

	function automatic logic [ALIVE_W-1:0] to_alive(input logic [CNT_W-1:0] c);
		logic [31:0] t;
		t = 32'(c);
		return t[ALIVE_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: src/tav_cell.sv
`default_nettype none

module tav_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire tav_pkg::cell_ctl_t        ctl,
	input  wire logic                      alloc_hit,
	input  wire logic [tav_pkg::LINK_W-1:0] link_init,
	input  wire logic                      tok_in,
	output logic                           tok_out,
	output logic [tav_pkg::LINK_W-1:0]     link,
	output logic                           rel
);

	logic                        tok_q;
	logic                        armed_q;
	logic [tav_pkg::DELAY_W-1:0] cd_q;
	// link stored relative to its reset value, so reset leaves index plus one
	logic [tav_pkg::LINK_W-1:0]  link_q;
	logic                        act;
	logic                        expire;

	assign act     = tok_q && ctl.step;
	assign expire  = armed_q && (cd_q <= tav_pkg::DELAY_W'(1));
	assign rel     = act && expire && !ctl.rel_full;
	assign link    = link_q ^ link_init;
	assign tok_out = tok_q;

	// Token shift, timer and free-list link
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= 1'b0;
			armed_q <= 1'b0;
			cd_q    <= '0;
			link_q  <= '0;
		end else begin
			if (ctl.step) begin
				tok_q <= tok_in;
			end
			if (ctl.clear) begin
				armed_q <= 1'b0;
				cd_q    <= '0;
				link_q  <= '0;
			end else if (alloc_hit) begin
				armed_q <= 1'b1;
				cd_q    <= ctl.alloc_delay;
			end else if (act && armed_q) begin
				if (expire) begin
					if (ctl.rel_full) begin
						cd_q <= tav_pkg::DELAY_W'(1);
					end else begin
						armed_q <= 1'b0;
						cd_q    <= '0;
						link_q  <= ctl.free_head ^ link_init;
					end
				end else begin
					cd_q <= cd_q - tav_pkg::DELAY_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: src/tav_ctrl.sv
`default_nettype none

module tav_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_valid,
	output logic                              s_ready,
	input  wire logic [tav_pkg::DELAY_W-1:0]  s_delay,
	input  wire logic [1:0]                   s_op,
	input  wire logic                         m_ready,
	output logic                              out_valid,
	output tav_pkg::res_t                     out_res,
	output tav_pkg::cell_ctl_t                ctl,
	output logic                              tok_start,
	input  wire logic                         tok_end,
	input  wire logic [tav_pkg::NUM_VOICES-1:0] rel,
	input  wire logic [tav_pkg::LINK_W-1:0]   links [tav_pkg::NUM_VOICES]
);

	tav_pkg::state_t              state_q, state_d;
	logic [tav_pkg::LINK_W-1:0]   free_head_q;
	logic [tav_pkg::CNT_W-1:0]    in_use_q;
	logic [tav_pkg::RCNT_W-1:0]   rel_cnt_q;
	logic                         pend_valid_q;
	tav_pkg::res_t                pend_q;
	logic                         out_valid_q;
	tav_pkg::res_t                out_q;

	logic                         adv;
	logic                         accept;
	logic                         empty;
	logic [tav_pkg::VIDX_W-1:0]   head_idx;
	logic [tav_pkg::LINK_W-1:0]   link_rd;
	logic [tav_pkg::LINK_W-1:0]   next_head;
	logic [tav_pkg::VIDX_W-1:0]   rel_idx;
	logic                         any_rel;
	logic [tav_pkg::CNT_W-1:0]    in_use_dec;
	logic [tav_pkg::DELAY_W-1:0]  delay_eff;
	logic                         out_load;

	// Output register frees up when empty or being taken
	assign adv       = !out_valid_q || m_ready;
	assign s_ready   = (state_q == tav_pkg::ST_IDLE) && adv;
	assign accept    = s_valid && s_ready;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign tok_start = accept && (s_op == tav_pkg::OP_TICK);

	// Free-list head lookup
	assign empty     = free_head_q >= tav_pkg::LINK_W'(tav_pkg::NUM_VOICES);
	assign head_idx  = free_head_q[tav_pkg::VIDX_W-1:0];
	assign link_rd   = links[head_idx];
	assign next_head = (link_rd > tav_pkg::LINK_W'(tav_pkg::NUM_VOICES)) ?
		tav_pkg::LINK_W'(tav_pkg::NUM_VOICES) : link_rd;
	assign delay_eff = (s_delay == '0) ? tav_pkg::DELAY_W'(1) : s_delay;
	assign in_use_dec = (in_use_q != '0) ? in_use_q - tav_pkg::CNT_W'(1) : in_use_q;

	// Index of the releasing cell; at most one holds the token
	always_comb begin
		rel_idx = '0;
		for (int i = 0; i < tav_pkg::NUM_VOICES; i++) begin
			if (rel[i]) begin
				rel_idx = rel_idx | tav_pkg::VIDX_W'(i);
			end
		end
	end
	assign any_rel = |rel;

	// Output register loads
	assign out_load = (accept && ((s_op == tav_pkg::OP_ALLOC) ||
			(s_op == tav_pkg::OP_CLEAR))) ||
		(any_rel && pend_valid_q) ||
		((state_q == tav_pkg::ST_FLUSH) && adv && pend_valid_q);

	// Cell broadcast
	always_comb begin
		ctl.clear       = accept && (s_op == tav_pkg::OP_CLEAR);
		ctl.step        = adv;
		ctl.alloc_wr    = accept && (s_op == tav_pkg::OP_ALLOC) && !empty;
		ctl.alloc_voice = head_idx;
		ctl.alloc_delay = delay_eff;
		ctl.free_head   = free_head_q;
		ctl.rel_full    = rel_cnt_q >= tav_pkg::RCNT_W'(tav_pkg::MAX_RESULTS);
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tav_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tav_pkg::ST_IDLE: begin
				if (tok_start) begin
					state_d = tav_pkg::ST_SCAN;
				end
			end
			tav_pkg::ST_SCAN: begin
				if (tok_end && adv) begin
					state_d = tav_pkg::ST_FLUSH;
				end
			end
			tav_pkg::ST_FLUSH: begin
				if (adv) begin
					state_d = tav_pkg::ST_IDLE;
				end
			end
			default: state_d = tav_pkg::ST_IDLE;
		endcase
	end

	// Pool bookkeeping, pending release and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q  <= '0;
			in_use_q     <= '0;
			rel_cnt_q    <= '0;
			pend_valid_q <= 1'b0;
			pend_q       <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				case (s_op)
					tav_pkg::OP_ALLOC: begin
						if (empty) begin
							out_q <= '{tav_pkg::KIND_EMPTY, '0,
								tav_pkg::to_alive(in_use_q), 1'b1};
						end else begin
							free_head_q <= next_head;
							in_use_q    <= in_use_q + tav_pkg::CNT_W'(1);
							out_q <= '{tav_pkg::KIND_ALLOC, tav_pkg::to_voice(head_idx),
								tav_pkg::to_alive(in_use_q + tav_pkg::CNT_W'(1)), 1'b1};
						end
					end
					tav_pkg::OP_TICK: begin
						rel_cnt_q    <= '0;
						pend_valid_q <= 1'b0;
					end
					tav_pkg::OP_CLEAR: begin
						free_head_q <= '0;
						in_use_q    <= '0;
						out_q       <= '{tav_pkg::KIND_CLEAR, '0, '0, 1'b1};
					end
					default: ;
				endcase
			end
			// A new release pushes the previous one out, not yet last
			if (any_rel) begin
				free_head_q  <= tav_pkg::LINK_W'(rel_idx);
				in_use_q     <= in_use_dec;
				rel_cnt_q    <= rel_cnt_q + tav_pkg::RCNT_W'(1);
				pend_valid_q <= 1'b1;
				pend_q       <= '{tav_pkg::KIND_RELEASE, tav_pkg::to_voice(rel_idx),
					tav_pkg::to_alive(in_use_dec), 1'b0};
				if (pend_valid_q) begin
					out_q <= pend_q;
				end
			end
			// End of scan: the held release is the last one
			if ((state_q == tav_pkg::ST_FLUSH) && adv) begin
				pend_valid_q <= 1'b0;
				if (pend_valid_q) begin
					out_q <= '{pend_q.kind, pend_q.voice, pend_q.alive, 1'b1};
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_rel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(rel))
		else $error("more than one cell released in a cycle");
	a_rel_scan: assert property (@(posedge clk) disable iff (!arst_n)
		any_rel |-> state_q == tav_pkg::ST_SCAN)
		else $error("release outside of a tick scan");
	a_in_use_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_use_q <= tav_pkg::CNT_W'(tav_pkg::NUM_VOICES))
		else $error("alive count above pool size");
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q <= tav_pkg::LINK_W'(tav_pkg::NUM_VOICES))
		else $error("free-list head out of range");
	a_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tav_pkg::ST_IDLE |-> !pend_valid_q)
		else $error("release left pending after a scan");
`endif

endmodule

`default_nettype wire

// File: src/timed_voice_allocator.sv
// Voice allocator with per-voice release timers and a LIFO free list.
// Input stream (s_*): s_tuser selects the operation (allocate, tick, clear),
// s_tdata carries the release delay in ticks for an allocate (0 acts as 1).
// Output stream (m_*): m_tuser is the result kind (allocated, released,
// cleared, pool empty), m_tdata holds voice and alive count, m_tlast marks
// the final result of one input transaction. A tick that frees no voice and
// operation code 3 give no result.
// Allocate and clear load their result straight into the output register; a new
// transaction is taken as soon as that register is free or being drained.
// A tick walks a token along the row of voice cells, one cell per cycle
// while the output register is free or being drained; releases come out in
// ascending voice order, at most one per cycle.
// While a result waits and the receiver holds m_tready low, the token stops
// and s_tready stays low; nothing is dropped.
// Reset puts all voices on the free list as 0..NUM_VOICES-1, disarms every
// timer and zeroes the alive count; a clear does the same.
`default_nettype none

module timed_voice_allocator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] delay_ticks
	input  wire logic [1:0]  s_tuser,   // [1:0] operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [3:0] voice, [8:4] alive_count, rest zero
	output logic [1:0]       m_tuser,   // [1:0] kind
	output logic             m_tlast
);

	tav_pkg::cell_ctl_t               ctl;
	tav_pkg::res_t                    res;
	logic                             tok_start;
	logic [tav_pkg::NUM_VOICES:0]     tok;
	logic [tav_pkg::NUM_VOICES-1:0]   rel;
	logic [tav_pkg::LINK_W-1:0]       links [tav_pkg::NUM_VOICES];

	tav_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_valid   (s_tvalid),
		.s_ready   (s_tready),
		.s_delay   (s_tdata),
		.s_op      (s_tuser),
		.m_ready   (m_tready),
		.out_valid (m_tvalid),
		.out_res   (res),
		.ctl       (ctl),
		.tok_start (tok_start),
		.tok_end   (tok[tav_pkg::NUM_VOICES]),
		.rel       (rel),
		.links     (links)
	);

	// Row of voice cells, token enters at voice 0
	assign tok[0] = tok_start;

	for (genvar i = 0; i < tav_pkg::NUM_VOICES; i++) begin : g_cell
		tav_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.alloc_hit (ctl.alloc_wr && (ctl.alloc_voice == tav_pkg::VIDX_W'(i))),
			.link_init (tav_pkg::LINK_W'(i + 1)),
			.tok_in    (tok[i]),
			.tok_out   (tok[i+1]),
			.link      (links[i]),
			.rel       (rel[i])
		);
	end

	// Output packing
	assign m_tdata = {7'd0, res.alive, res.voice};
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

endmodule

`default_nettype wire

// File: tb/timed_voice_allocator_tb.sv
`timescale 1ns / 100ps

module timed_voice_allocator_tb;

	// Operation code the block ignores
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// Cycles with no transaction on either side before the run is stopped
	localparam int IDLE_LIMIT = 3000;
	// A tick walks all voice cells; the settle time covers that, plus margin
	localparam int SETTLE_CYCLES = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [15:0] delay_ticks
	logic [1:0]  s_tuser = '0;   // [1:0] operation
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [3:0] voice, [8:4] alive_count, rest zero
	logic [1:0]  m_tuser;        // [1:0] kind
	logic        m_tlast;

	// Shadow copy of the voice pool
	logic [4:0]  link_q [tav_pkg::NUM_VOICES];
	logic [4:0]  head_q;
	logic [15:0] timer_q [tav_pkg::NUM_VOICES];
	logic        armed_q [tav_pkg::NUM_VOICES];
	logic [4:0]  alive_q;

	tav_pkg::res_t pool_events_q [$];

	int mismatch_count = 0;
	int idle_cycles = 0;
	int sink_hold = 0;
	int sink_gap = 0;
	bit src_idle_en = 1'b1;
	bit sink_stall_en = 1'b1;

	timed_voice_allocator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Gap length: mostly none, often short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic tav_pkg::res_t make_event(input logic [1:0] kind,
			input logic [3:0] voice, input logic [4:0] alive, input logic last);
		tav_pkg::res_t r;
		r.kind  = kind;
		r.voice = voice;
		r.alive = alive;
		r.last  = last;
		return r;
	endfunction

	// Full free list in index order, all timers stopped
	task automatic rebuild_pool_model();
		for (int i = 0; i < tav_pkg::NUM_VOICES; i++) begin
			link_q[i]  = 5'(i + 1);
			timer_q[i] = '0;
			armed_q[i] = 1'b0;
		end
		head_q  = '0;
		alive_q = '0;
	endtask

	// Update the shadow pool for one accepted transaction and queue its events
	task automatic predict_pool_events(input logic [1:0] op, input logic [15:0] delay);
		int v;
		int n;
		logic [3:0] rel_voice [tav_pkg::MAX_RESULTS];
		logic [4:0] rel_alive [tav_pkg::MAX_RESULTS];
		n = 0;
		case (op)
			tav_pkg::OP_ALLOC: begin
				if (head_q >= tav_pkg::NUM_VOICES) begin
					pool_events_q.push_back(make_event(tav_pkg::KIND_EMPTY, '0,
						alive_q, 1'b1));
				end else begin
					v = head_q;
					head_q = link_q[v];
					if (head_q > tav_pkg::NUM_VOICES)
						head_q = 5'(tav_pkg::NUM_VOICES);
					timer_q[v] = (delay == 0) ? 16'd1 : delay;
					armed_q[v] = 1'b1;
					alive_q = alive_q + 5'd1;
					pool_events_q.push_back(make_event(tav_pkg::KIND_ALLOC, 4'(v),
						alive_q, 1'b1));
				end
			end
			tav_pkg::OP_TICK: begin
				for (int i = 0; i < tav_pkg::NUM_VOICES; i++) begin
					if (armed_q[i]) begin
						if (timer_q[i] <= 1) begin
							if (n >= tav_pkg::MAX_RESULTS) begin
								// no room this tick, expires on the next one
								timer_q[i] = 16'd1;
							end else begin
								timer_q[i] = '0;
								armed_q[i] = 1'b0;
								link_q[i] = head_q;
								head_q = 5'(i);
								if (alive_q > 0)
									alive_q = alive_q - 5'd1;
								rel_voice[n] = 4'(i);
								rel_alive[n] = alive_q;
								n++;
							end
						end else begin
							timer_q[i] = timer_q[i] - 16'd1;
						end
					end
				end
				for (int i = 0; i < n; i++)
					pool_events_q.push_back(make_event(tav_pkg::KIND_RELEASE,
						rel_voice[i], rel_alive[i], i == n - 1));
			end
			tav_pkg::OP_CLEAR: begin
				rebuild_pool_model();
				pool_events_q.push_back(make_event(tav_pkg::KIND_CLEAR, '0, '0, 1'b1));
			end
			default: ;
		endcase
	endtask

	// Offer one transaction, wait for acceptance, then predict it
	task automatic send_item(input logic [1:0] op, input logic [15:0] delay);
		int gap;
		gap = src_idle_en ? gap_len() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= delay;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_pool_events(op, delay);
	endtask

	// Stop offering and wait for every queued event
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pool_events_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [1:0] pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 48)
			return tav_pkg::OP_ALLOC;
		else if (r < 92)
			return tav_pkg::OP_TICK;
		else if (r < 96)
			return tav_pkg::OP_CLEAR;
		return OP_UNUSED;
	endfunction

	// Short delays so voices cycle; a few full-range ones
	function automatic logic [15:0] pick_delay();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 16'($urandom_range(0, 6));
		else if (r < 90)
			return 16'($urandom_range(7, 60));
		return 16'($urandom);
	endfunction

	// Zero and maximum delay, quiet tick, ignored code, clear
	task automatic test_corner_items();
		send_item(tav_pkg::OP_ALLOC, 16'h0000);
		send_item(tav_pkg::OP_ALLOC, 16'hFFFF);
		send_item(tav_pkg::OP_TICK, 16'h5A5A);
		send_item(tav_pkg::OP_TICK, 16'hA5A5);
		send_item(OP_UNUSED, 16'hFFFF);
		send_item(tav_pkg::OP_CLEAR, 16'h0000);
	endtask

	// Exhaust the pool, hit pool empty, then release all voices in one tick
	task automatic test_full_pool();
		for (int i = 0; i < tav_pkg::NUM_VOICES; i++)
			send_item(tav_pkg::OP_ALLOC, 16'(i % 2));
		send_item(tav_pkg::OP_ALLOC, 16'h8001);
		send_item(tav_pkg::OP_TICK, 16'h0000);
		send_item(tav_pkg::OP_CLEAR, 16'hFFFF);
	endtask

	// Random mix with stretches where neither side idles
	task automatic test_random_mix(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 40) begin
				src_idle_en   = 1'b0;
				sink_stall_en = 1'b0;
			end else if (i % 60 == 0) begin
				src_idle_en   = 1'b1;
				sink_stall_en = 1'b1;
			end
			send_item(pick_op(), pick_delay());
		end
		src_idle_en   = 1'b1;
		sink_stall_en = 1'b1;
	endtask

	// Receiver holds off long while the sender keeps offering
	task automatic test_backpressure();
		src_idle_en = 1'b0;
		sink_hold = 200;
		for (int i = 0; i < 40; i++)
			send_item((i % 3 == 2) ? tav_pkg::OP_TICK : tav_pkg::OP_ALLOC,
				16'($urandom_range(0, 3)));
		src_idle_en = 1'b1;
		wait_drained();
	endtask

	// Back-to-back traffic with the receiver always ready
	task automatic test_full_rate(input int count);
		src_idle_en   = 1'b0;
		sink_stall_en = 1'b0;
		for (int i = 0; i < count; i++)
			send_item(pick_op(), pick_delay());
		src_idle_en   = 1'b1;
		sink_stall_en = 1'b1;
	endtask

	// Receiver: long hold-off first, else random gaps
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			m_tready <= 1'b0;
			sink_hold = sink_hold - 1;
		end else if (sink_gap > 0) begin
			m_tready <= 1'b0;
			sink_gap = sink_gap - 1;
		end else begin
			m_tready <= 1'b1;
			if (sink_stall_en)
				sink_gap = gap_len();
		end
	end

	// Compare each result transaction with the oldest expected event
	always @(posedge clk) begin
		tav_pkg::res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pool_events_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected result kind=%0d voice=%0d alive=%0d last=%0b",
						$time, m_tuser, m_tdata[3:0], m_tdata[8:4], m_tlast);
			end else begin
				want = pool_events_q.pop_front();
				if (m_tuser !== want.kind || m_tdata[3:0] !== want.voice ||
						m_tdata[8:4] !== want.alive || m_tlast !== want.last ||
						m_tdata[15:9] !== 7'd0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t: expected kind=%0d voice=%0d alive=%0d last=%0b",
							$time, want.kind, want.voice, want.alive, want.last);
						$display("%0t: got kind=%0d voice=%0d alive=%0d last=%0b pad=%h",
							$time, m_tuser, m_tdata[3:0], m_tdata[8:4], m_tlast,
							m_tdata[15:9]);
					end
				end
			end
		end
	end

	// Watchdog: stop when neither side moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		rebuild_pool_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_items();
		wait_drained();
		test_full_pool();
		test_random_mix(255);
		test_backpressure();
		test_full_rate(60);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pool_events_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
